// File: design/rvx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared opcodes, unit classes, latencies and helpers for the RV64IM execute ALU.
// ----------------------------------------------------------------------------
package rvx_pkg;

  localparam int XLEN    = 64;
  localparam int ALU_LAT = 1;
  localparam int MUL_LAT = 3;
  localparam int DIV_LAT = XLEN + 2;

  localparam logic [5:0] SHAMT64_MASK = 6'h3f;
  localparam logic [4:0] SHAMT32_MASK = 5'h1f;

  typedef enum logic [5:0] {
    OP_ADD = 6'd0, OP_MUL = 6'd1, OP_SUB = 6'd2, OP_SLL = 6'd3, OP_MULH = 6'd4,
    OP_SLT = 6'd5, OP_XOR = 6'd6, OP_DIV = 6'd7, OP_SRL = 6'd8, OP_SRA = 6'd9,
    OP_OR = 6'd10, OP_REM = 6'd11, OP_AND = 6'd12, OP_ADDW = 6'd13, OP_SUBW = 6'd14,
    OP_MULW = 6'd15, OP_DIVW = 6'd16, OP_REMW = 6'd17, OP_SLLW = 6'd18,
    OP_SRLW = 6'd19, OP_SRAW = 6'd20, OP_LDST = 6'd21, OP_ADDI = 6'd22,
    OP_SLLI = 6'd23, OP_SRLI = 6'd24, OP_SRAI = 6'd25, OP_SLLW_IMM = 6'd26,
    OP_SLTI = 6'd27, OP_XORI = 6'd28, OP_SRLW_IMM = 6'd29, OP_SRAW_IMM = 6'd30,
    OP_ORI = 6'd31, OP_ANDI = 6'd32, OP_ADDW_IMM = 6'd33, OP_JALR = 6'd34,
    OP_BEQ = 6'd35, OP_BNE = 6'd36, OP_BLT = 6'd37, OP_BGE = 6'd38,
    OP_BLTU = 6'd39, OP_BGEU = 6'd40, OP_PC_ADD_UPPER = 6'd41, OP_LUI = 6'd42,
    OP_JAL = 6'd43
  } op_t;

  typedef enum logic [1:0] {
    CLS_ALU = 2'd0,
    CLS_MUL = 2'd1,
    CLS_DIV = 2'd2
  } cls_t;

  function automatic logic [XLEN-1:0] sx32(input logic [XLEN-1:0] v);
    return {{(XLEN-32){v[31]}}, v[31:0]};
  endfunction

endpackage

// File: design/rv64im_execute_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64im_execute_alu
// RV64IM execute stage: integer ALU, pipelined multiplier and divider.
//
//   channel | signals                                      | dir
//   in      | in_valid in_ready opcode operand_a operand_b  | in
//           | immediate pc                                 |
//   out     | out_valid out_ready result branch_taken      | out
//
// one beat per cycle sustained while the output is not stalled; every path is
// as long as the 64-stage restoring divider plus prep, fixup and output regs
// every op takes the same path length so results leave in order
// rst clears the valid bits only; payload registers are not reset
// a stalled output freezes the whole pipeline; nothing is lost or repeated
// ----------------------------------------------------------------------------
module rv64im_execute_alu import rvx_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [5:0]       opcode,
  input  logic [63:0]      operand_a,
  input  logic [63:0]      operand_b,
  input  logic [31:0]      immediate,
  input  logic [63:0]      pc,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      result,
  output logic             branch_taken
);

  localparam int ALU_PAD = DIV_LAT - ALU_LAT;
  localparam int MUL_PAD = DIV_LAT - MUL_LAT;

  logic            en;
  logic            vld [0:DIV_LAT];

  logic [5:0]      op0;
  logic [XLEN-1:0] a0, b0, c0, pc0;
  cls_t            cls_in;

  logic [XLEN-1:0] alu_res;
  logic            alu_tk;
  logic [XLEN-1:0] mul_res;
  logic [XLEN-1:0] div_res;

  logic [XLEN-1:0] alu_d [0:ALU_PAD-1];
  logic            tk_d  [0:ALU_PAD-1];
  logic [XLEN-1:0] mul_d [0:MUL_PAD-1];
  cls_t            cls_d [0:DIV_LAT-1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en && !rst;

  always_comb begin
    if (op0 inside {OP_MUL, OP_MULH, OP_MULW}) begin
      cls_in = CLS_MUL;
    end else if (op0 inside {OP_DIV, OP_REM, OP_DIVW, OP_REMW}) begin
      cls_in = CLS_DIV;
    end else begin
      cls_in = CLS_ALU;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_LAT; k++) vld[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k <= DIV_LAT; k++) vld[k] <= vld[k-1];
      out_valid <= vld[DIV_LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0 <= opcode;
      a0  <= operand_a;
      b0  <= operand_b;
      c0  <= {{(XLEN-32){immediate[31]}}, immediate};
      pc0 <= pc;

      alu_d[0] <= alu_res;
      tk_d[0]  <= alu_tk;
      for (int k = 1; k < ALU_PAD; k++) begin
        alu_d[k] <= alu_d[k-1];
        tk_d[k]  <= tk_d[k-1];
      end
      mul_d[0] <= mul_res;
      for (int k = 1; k < MUL_PAD; k++) mul_d[k] <= mul_d[k-1];
      cls_d[0] <= cls_in;
      for (int k = 1; k < DIV_LAT; k++) cls_d[k] <= cls_d[k-1];

      case (cls_d[DIV_LAT-1])
        CLS_MUL: begin
          result       <= mul_d[MUL_PAD-1];
          branch_taken <= 1'b0;
        end
        CLS_DIV: begin
          result       <= div_res;
          branch_taken <= 1'b0;
        end
        default: begin
          result       <= alu_d[ALU_PAD-1];
          branch_taken <= tk_d[ALU_PAD-1];
        end
      endcase
    end
  end

  rvx_alu u_alu (
    .clk   (clk),
    .en    (en),
    .op    (op0),
    .a     (a0),
    .b     (b0),
    .c     (c0),
    .pc    (pc0),
    .res   (alu_res),
    .taken (alu_tk)
  );

  rvx_mul u_mul (
    .clk  (clk),
    .en   (en),
    .a    (a0),
    .b    (b0),
    .high (op0 == OP_MULH),
    .word (op0 == OP_MULW),
    .res  (mul_res)
  );

  rvx_div u_div (
    .clk     (clk),
    .en      (en),
    .a       (a0),
    .b       (b0),
    .word    (op0 == OP_DIVW || op0 == OP_REMW),
    .rem_sel (op0 == OP_REM || op0 == OP_REMW),
    .res     (div_res)
  );

endmodule

// File: design/rvx_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_alu
// Registered integer unit: add/sub, shifts, compares, logic, targets, branches.
// ----------------------------------------------------------------------------
module rvx_alu import rvx_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [5:0]      op,
  input  logic [XLEN-1:0] a,
  input  logic [XLEN-1:0] b,
  input  logic [XLEN-1:0] c,
  input  logic [XLEN-1:0] pc,
  output logic [XLEN-1:0] res,
  output logic            taken
);

  logic [XLEN-1:0] r;
  logic            t;
  logic [5:0]      shr;
  logic [4:0]      shrw;
  logic [5:0]      shi;
  logic [4:0]      shiw;
  logic [XLEN-1:0] pc_c;
  logic [XLEN-1:0] a_c;
  logic            lt_s;
  logic            lt_u;

  always_comb begin
    shr  = b[5:0] & SHAMT64_MASK;
    shrw = b[4:0] & SHAMT32_MASK;
    shi  = c[5:0] & SHAMT64_MASK;
    shiw = c[4:0] & SHAMT32_MASK;
    pc_c = pc + c;
    a_c  = a + c;
    lt_s = $signed(a) < $signed(b);
    lt_u = a < b;
    r = '0;
    t = 1'b0;
    case (op)
      OP_ADD:   r = a + b;
      OP_SUB:   r = a - b;
      OP_SLL:   r = a << shr;
      OP_SLT:   r = {{(XLEN-1){1'b0}}, lt_s};
      OP_XOR:   r = a ^ b;
      OP_SRL:   r = a >> shr;
      OP_SRA:   r = $signed(a) >>> shr;
      OP_OR:    r = a | b;
      OP_AND:   r = a & b;
      OP_ADDW:  r = sx32(a + b);
      OP_SUBW:  r = sx32(a - b);
      OP_SLLW:  r = sx32(a << shrw);
      OP_SRLW:  r = sx32({32'b0, a[31:0]} >> shrw);
      OP_SRAW:  r = sx32($signed(sx32(a)) >>> shrw);
      OP_LDST:  r = a_c;
      OP_ADDI:  r = a_c;
      OP_SLLI:  r = a << shi;
      OP_SRLI:  r = a >> shi;
      OP_SRAI:  r = $signed(a) >>> shi;
      OP_SLLW_IMM: r = sx32(a << shiw);
      OP_SLTI:  r = {{(XLEN-1){1'b0}}, $signed(a) < $signed(c)};
      OP_XORI:  r = a ^ c;
      OP_SRLW_IMM: r = sx32({32'b0, a[31:0]} >> shiw);
      OP_SRAW_IMM: r = sx32($signed(sx32(a)) >>> shiw);
      OP_ORI:   r = a | c;
      OP_ANDI:  r = a & c;
      OP_ADDW_IMM: r = sx32(a_c);
      OP_JALR:  r = {a_c[XLEN-1:1], 1'b0};
      OP_BEQ:   begin r = pc_c; t = a == b; end
      OP_BNE:   begin r = pc_c; t = a != b; end
      OP_BLT:   begin r = pc_c; t = lt_s; end
      OP_BGE:   begin r = pc_c; t = !lt_s; end
      OP_BLTU:  begin r = pc_c; t = lt_u; end
      OP_BGEU:  begin r = pc_c; t = !lt_u; end
      OP_PC_ADD_UPPER: r = pc_c;
      OP_LUI:   r = c;
      OP_JAL:   r = pc_c;
      default:  r = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res   <= r;
      taken <= t;
    end
  end

endmodule

// File: design/rvx_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_mul
// Three-stage multiplier: 32x32 partial products, column sums, signed high fixup.
// ----------------------------------------------------------------------------
module rvx_mul import rvx_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [XLEN-1:0] a,
  input  logic [XLEN-1:0] b,
  input  logic            high,
  input  logic            word,
  output logic [XLEN-1:0] res
);

  logic [63:0]     p00, p01, p10, p11;
  logic [XLEN-1:0] a1, b1;
  logic            high1, word1;

  logic [33:0]     mid;
  logic [XLEN-1:0] lo2, hp2, corr2;
  logic [1:0]      mc2;
  logic            high2, word2;

  logic [XLEN-1:0] hi3;

  assign mid = {2'b0, p00[63:32]} + {2'b0, p01[31:0]} + {2'b0, p10[31:0]};
  assign hi3 = hp2 + {{(XLEN-2){1'b0}}, mc2} - corr2;

  always_ff @(posedge clk) begin
    if (en) begin
      p00   <= a[31:0] * b[31:0];
      p01   <= a[31:0] * b[63:32];
      p10   <= a[63:32] * b[31:0];
      p11   <= a[63:32] * b[63:32];
      a1    <= a;
      b1    <= b;
      high1 <= high;
      word1 <= word;

      lo2   <= {mid[31:0], p00[31:0]};
      mc2   <= mid[33:32];
      hp2   <= p11 + {32'b0, p01[63:32]} + {32'b0, p10[63:32]};
      corr2 <= (a1[XLEN-1] ? b1 : '0) + (b1[XLEN-1] ? a1 : '0);
      high2 <= high1;
      word2 <= word1;

      res   <= high2 ? hi3 : (word2 ? sx32(lo2) : lo2);
    end
  end

endmodule

// File: design/rvx_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_div
// Pipelined signed divider: sign prep, one restoring step per stage, sign fixup.
// ----------------------------------------------------------------------------
module rvx_div import rvx_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [XLEN-1:0] a,
  input  logic [XLEN-1:0] b,
  input  logic            word,
  input  logic            rem_sel,
  output logic [XLEN-1:0] res
);

  logic [XLEN-1:0] rem_s [0:XLEN];
  logic [XLEN-1:0] quo_s [0:XLEN];
  logic [XLEN-1:0] dvs_s [0:XLEN-1];
  logic            nq_s  [0:XLEN];
  logic            nr_s  [0:XLEN];
  logic            zero_s[0:XLEN];
  logic            word_s[0:XLEN];
  logic            rsel_s[0:XLEN];

  logic [XLEN-1:0] aa, bb, ua, ub;
  logic [XLEN-1:0] qf, rf, vf;

  function automatic logic [XLEN:0] div_step(input logic [XLEN-1:0] rm,
                                             input logic            qb,
                                             input logic [XLEN-1:0] d);
    logic [XLEN:0] t;
    logic [XLEN:0] diff;
    t    = {rm, qb};
    diff = t - {1'b0, d};
    return diff[XLEN] ? {1'b0, t[XLEN-1:0]} : {1'b1, diff[XLEN-1:0]};
  endfunction

  always_comb begin
    aa = word ? sx32(a) : a;
    bb = word ? sx32(b) : b;
    ua = aa[XLEN-1] ? -aa : aa;
    ub = bb[XLEN-1] ? -bb : bb;
    qf = zero_s[XLEN] ? '1 : (nq_s[XLEN] ? -quo_s[XLEN] : quo_s[XLEN]);
    rf = nr_s[XLEN] ? -rem_s[XLEN] : rem_s[XLEN];
    vf = rsel_s[XLEN] ? rf : qf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0]  <= '0;
      quo_s[0]  <= ua;
      dvs_s[0]  <= ub;
      nq_s[0]   <= aa[XLEN-1] ^ bb[XLEN-1];
      nr_s[0]   <= aa[XLEN-1];
      zero_s[0] <= bb == '0;
      word_s[0] <= word;
      rsel_s[0] <= rem_sel;
      for (int k = 1; k <= XLEN; k++) begin
        {quo_s[k][0], rem_s[k]} <= div_step(rem_s[k-1], quo_s[k-1][XLEN-1], dvs_s[k-1]);
        quo_s[k][XLEN-1:1] <= quo_s[k-1][XLEN-2:0];
        nq_s[k]   <= nq_s[k-1];
        nr_s[k]   <= nr_s[k-1];
        zero_s[k] <= zero_s[k-1];
        word_s[k] <= word_s[k-1];
        rsel_s[k] <= rsel_s[k-1];
      end
      for (int k = 1; k < XLEN; k++) dvs_s[k] <= dvs_s[k-1];
      res <= word_s[XLEN] ? sx32(vf) : vf;
    end
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the RV64IM execute ALU. Directed beats cover corners (division
// by zero, signed overflow, shift masks, branch flags, unused codes), then each
// opcode code gets a beat, then random beats weighted toward the interesting
// operand values. A predictor computes the expected result of each accepted
// beat and a checker compares results in order. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top import rvx_pkg::*; ();

  localparam int PIPE_DEPTH = 68;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [63:0] value;
    logic        taken;
  } alu_out_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [5:0]  opcode;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  logic [31:0] immediate;
  logic [63:0] pc;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] result;
  logic        branch_taken;

  alu_out_t expected_q[$];
  int       mismatch_count;
  int       idle_cycles;
  bit       timed_out;
  bit       hold_receiver;
  int       hold_cycles;

  rv64im_execute_alu i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
    .immediate(immediate), .pc(pc),
    .out_valid(out_valid), .out_ready(out_ready),
    .result(result), .branch_taken(branch_taken)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] sext_word(input logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  function automatic logic [63:0] signed_quot(input logic [63:0] a, input logic [63:0] b);
    if (b == 64'd0) return '1;
    if (a == {1'b1, 63'd0} && b == '1) return a;
    return $signed(a) / $signed(b);
  endfunction

  function automatic logic [63:0] signed_rem(input logic [63:0] a, input logic [63:0] b);
    if (b == 64'd0) return a;
    if (a == {1'b1, 63'd0} && b == '1) return 64'd0;
    return $signed(a) % $signed(b);
  endfunction

  function automatic alu_out_t compute_alu(input logic [5:0] op, input logic [63:0] a,
                                           input logic [63:0] b, input logic [31:0] imm,
                                           input logic [63:0] addr);
    alu_out_t    r;
    logic [63:0] c;
    logic [127:0] prod;
    logic [5:0]  sh_r;
    logic [4:0]  sh_rw;
    logic [5:0]  sh_i;
    logic [4:0]  sh_iw;
    c = {{32{imm[31]}}, imm};
    sh_r = b[5:0];
    sh_rw = b[4:0];
    sh_i = c[5:0];
    sh_iw = c[4:0];
    r.value = 64'd0;
    r.taken = 1'b0;
    case (op)
      OP_ADD:   r.value = a + b;
      OP_MUL:   r.value = a * b;
      OP_SUB:   r.value = a - b;
      OP_SLL:   r.value = a << sh_r;
      OP_MULH: begin
        prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
        r.value = prod[127:64];
      end
      OP_SLT:   r.value = {63'd0, $signed(a) < $signed(b)};
      OP_XOR:   r.value = a ^ b;
      OP_DIV:   r.value = signed_quot(a, b);
      OP_SRL:   r.value = a >> sh_r;
      OP_SRA:   r.value = $signed(a) >>> sh_r;
      OP_OR:    r.value = a | b;
      OP_REM:   r.value = signed_rem(a, b);
      OP_AND:   r.value = a & b;
      OP_ADDW:  r.value = sext_word(a + b);
      OP_SUBW:  r.value = sext_word(a - b);
      OP_MULW:  r.value = sext_word(a * b);
      OP_DIVW:  r.value = sext_word(signed_quot(sext_word(a), sext_word(b)));
      OP_REMW:  r.value = sext_word(signed_rem(sext_word(a), sext_word(b)));
      OP_SLLW:  r.value = sext_word({32'd0, a[31:0]} << sh_rw);
      OP_SRLW:  r.value = sext_word({32'd0, a[31:0]} >> sh_rw);
      OP_SRAW:  r.value = $signed(sext_word(a)) >>> sh_rw;
      OP_LDST, OP_ADDI: r.value = a + c;
      OP_SLLI:  r.value = a << sh_i;
      OP_SRLI:  r.value = a >> sh_i;
      OP_SRAI:  r.value = $signed(a) >>> sh_i;
      OP_SLLW_IMM: r.value = sext_word({32'd0, a[31:0]} << sh_iw);
      OP_SLTI:  r.value = {63'd0, $signed(a) < $signed(c)};
      OP_XORI:  r.value = a ^ c;
      OP_SRLW_IMM: r.value = sext_word({32'd0, a[31:0]} >> sh_iw);
      OP_SRAW_IMM: r.value = $signed(sext_word(a)) >>> sh_iw;
      OP_ORI:   r.value = a | c;
      OP_ANDI:  r.value = a & c;
      OP_ADDW_IMM: r.value = sext_word(a + c);
      OP_JALR:  r.value = (a + c) & ~64'd1;
      OP_BEQ, OP_BNE, OP_BLT, OP_BGE, OP_BLTU, OP_BGEU: begin
        r.value = addr + c;
        case (op)
          OP_BEQ:  r.taken = (a == b);
          OP_BNE:  r.taken = (a != b);
          OP_BLT:  r.taken = $signed(a) < $signed(b);
          OP_BGE:  r.taken = $signed(a) >= $signed(b);
          OP_BLTU: r.taken = a < b;
          default: r.taken = a >= b;
        endcase
      end
      OP_PC_ADD_UPPER, OP_JAL: r.value = addr + c;
      OP_LUI:   r.value = c;
      default:  r.value = 64'd0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return '1;
      2: return {1'b1, 63'd0};
      3: return {1'b0, {63{1'b1}}};
      4: return {{32{$urandom_range(0, 1) == 1}}, 32'h8000_0000};
      5: return 64'($urandom_range(0, 70));
      6: return -64'($urandom_range(1, 70));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    repeat (n) @(posedge clk);
  endtask

  task automatic send_beat(input logic [5:0] op, input logic [63:0] a, input logic [63:0] b,
                           input logic [31:0] imm, input logic [63:0] addr, input bit gaps);
    in_valid  <= 1'b1;
    opcode    <= op;
    operand_a <= a;
    operand_b <= b;
    immediate <= imm;
    pc        <= addr;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(compute_alu(op, a, b, imm, addr));
    if (gaps && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      @(posedge clk);
      idle_gap();
    end
  endtask

  task automatic drop_valid();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    drop_valid();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_corners();
    logic [63:0] mn;
    mn = {1'b1, 63'd0};
    send_beat(OP_DIV,  mn, '1, 32'd0, 64'd0, 0);
    send_beat(OP_REM,  mn, '1, 32'd0, 64'd0, 0);
    send_beat(OP_DIV,  64'd77, 64'd0, 32'd0, 64'd0, 0);
    send_beat(OP_REM,  -64'd77, 64'd0, 32'd0, 64'd0, 0);
    send_beat(OP_DIVW, 64'hdead_beef_8000_0000, 64'h1234_ffff_ffff, 32'd0, 64'd0, 0);
    send_beat(OP_REMW, 64'hdead_beef_8000_0000, 64'h1234_ffff_ffff, 32'd0, 64'd0, 0);
    send_beat(OP_DIVW, 64'h5555_0000_1234_5678, 64'hffff_0000_0000_0000, 32'd0, 64'd0, 0);
    send_beat(OP_REMW, 64'h5555_0000_8234_5678, 64'hffff_0000_0000_0000, 32'd0, 64'd0, 0);
    send_beat(OP_MULH, mn, mn, 32'd0, 64'd0, 0);
    send_beat(OP_MUL,  '1, '1, 32'd0, 64'd0, 0);
    send_beat(OP_SLL,  64'd1, 64'hffff_ffff_ffff_ffff, 32'd0, 64'd0, 0);
    send_beat(OP_SRAW, 64'h8000_0000, 64'h3f, 32'd0, 64'd0, 0);
    send_beat(OP_SRAI, mn, 64'd0, 32'hffff_ffff, 64'd0, 0);
    send_beat(OP_SLLW_IMM, 64'hffff_ffff, 64'd0, 32'h7fff_ffff, 64'd0, 0);
    send_beat(OP_ADDW, 64'h7fff_ffff, 64'd1, 32'd0, 64'd0, 0);
    send_beat(OP_JALR, 64'd101, 64'd0, 32'h8000_0000, 64'd0, 0);
    send_beat(OP_LUI,  64'd0, 64'd0, 32'h8000_0000, '1, 0);
    send_beat(OP_JAL,  64'd0, 64'd0, 32'h7fff_ffff, '1, 0);
    send_beat(OP_BEQ,  64'd5, 64'd5, 32'hffff_fff0, 64'd0, 0);
    send_beat(OP_BLT,  mn, 64'd0, 32'd16, '1, 0);
    send_beat(OP_BLTU, mn, 64'd0, 32'd16, 64'd8, 0);
    send_beat(OP_BGEU, '1, '1, 32'd4, 64'd8, 0);
    send_beat(6'd44, '1, '1, '1, '1, 0);
    send_beat(6'd63, '1, 64'd0, '1, '1, 0);
    wait_drained();
  endtask

  task automatic test_every_opcode();
    for (int op = 0; op < 64; op++)
      send_beat(6'(op), pick_operand(), pick_operand(), $urandom, {$urandom, $urandom}, 1);
    wait_drained();
  endtask

  task automatic test_random_beats(input int count);
    logic [5:0] op;
    for (int i = 0; i < count; i++) begin
      op = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(44, 63)) : 6'($urandom_range(0, 43));
      send_beat(op, pick_operand(), pick_operand(),
                ($urandom_range(0, 3) == 0) ? 32'(pick_operand()) : $urandom,
                {$urandom, $urandom}, 1);
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    hold_cycles = 150;
    hold_receiver = 1'b1;
    for (int i = 0; i < 120; i++)
      send_beat(6'($urandom_range(0, 43)), pick_operand(), pick_operand(), $urandom,
                {$urandom, $urandom}, 0);
    wait_drained();
  endtask

  // receiver: random stalls plus an occasional long hold
  initial begin
    out_ready = 1'b0;
    hold_receiver = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_receiver = 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        idle_gap();
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // in-order result checker
  always @(posedge clk) begin
    alu_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected beat: result=%h taken=%b", result, branch_taken);
      end else begin
        want = expected_q.pop_front();
        if (want.value !== result || want.taken !== branch_taken) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp result=%h taken=%b, got result=%h taken=%b",
                     want.value, want.taken, result, branch_taken);
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) timed_out <= 1'b1;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0;
    operand_a = '0;
    operand_b = '0;
    immediate = '0;
    pc = '0;
    mismatch_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    fork
      begin
        test_directed_corners();
        test_every_opcode();
        test_output_backpressure();
        test_random_beats(1000);
        repeat (PIPE_DEPTH + 10) @(posedge clk);
      end
      wait (timed_out);
    join_any
    if (!timed_out && expected_q.size() == 0 && mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/rvx_pkg.sv
design/rvx_alu.sv
design/rvx_mul.sv
design/rvx_div.sv
design/rv64im_execute_alu.sv
bench/tb_top.sv
